// ===== rtl/rtp_pkg.sv =====
package rtp_pkg;

	// Default table size; the top level parameter can override it (1 to 256).
	localparam int unsigned REGION_COUNT_DEF = 16;

	localparam int unsigned OPCODE_W  = 2;
	localparam int unsigned REGION_W  = 8;
	localparam int unsigned TIME_W    = 64;
	localparam int unsigned COUNT_W   = 32;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned MARK_W    = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ENTER = 2'd0,
		OP_EXIT  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_ENTER = 2'd2;

	localparam logic [MARK_W-1:0] MARK_NONE  = 2'd0;
	localparam logic [MARK_W-1:0] MARK_ENTER = 2'd1;
	localparam logic [MARK_W-1:0] MARK_EXIT  = 2'd2;

	// One region record.
	typedef struct packed {
		logic [COUNT_W-1:0] entry_total;
		logic [COUNT_W-1:0] exit_total;
		logic [TIME_W-1:0]  busy_time;
		logic [TIME_W-1:0]  start_stamp;
		logic               region_open;
	} rec_t;

endpackage

// ===== rtl/rtp_in_if.sv =====
interface rtp_in_if;
	logic                            valid;
	logic                            ready;
	logic [rtp_pkg::OPCODE_W-1:0]    opcode;
	logic [rtp_pkg::REGION_W-1:0]    region;
	logic [rtp_pkg::TIME_W-1:0]      now_time;

	modport source (output valid, output opcode, output region, output now_time, input ready);
	modport sink   (input valid, input opcode, input region, input now_time, output ready);
endinterface

// ===== rtl/rtp_out_if.sv =====
interface rtp_out_if;
	logic                            valid;
	logic                            ready;
	logic [rtp_pkg::STATUS_W-1:0]    status;
	logic [rtp_pkg::MARK_W-1:0]      edge_mark;
	logic [rtp_pkg::COUNT_W-1:0]     entry_total;
	logic [rtp_pkg::COUNT_W-1:0]     exit_total;
	logic [rtp_pkg::TIME_W-1:0]      busy_time;
	logic [rtp_pkg::TIME_W-1:0]      start_stamp;
	logic                            region_open;

	modport source (output valid, output status, output edge_mark, output entry_total,
		output exit_total, output busy_time, output start_stamp, output region_open,
		input ready);
	modport sink   (input valid, input status, input edge_mark, input entry_total,
		input exit_total, input busy_time, input start_stamp, input region_open,
		output ready);
endinterface

// ===== rtl/region_time_profiler_core.sv =====
// Region time profiler.
// cmd channel: one transfer carries opcode (enter, exit, read, clear all),
//   region number and the current microsecond time.
// res channel: exactly one transfer per command: status, enter/exit mark and
//   the region record after the operation (all zero for clear and range error).
// Pipeline: an accepted command goes through one input register, then one
//   result register. Throughput: one command per cycle while res is ready.
// The record table is a flop array read at one address and written back in
//   the same cycle the result register loads, so the next command already
//   sees the update; no forwarding is needed.
// Reset (arst_n low): all table valid bits clear, so every record reads as
//   zero; both pipeline stages empty. No sweep, cmd is ready right after reset.
// Clear all clears all the valid bits at once.
// Stall: while res.ready is low the result register holds; one more command
//   can sit in the input register, then cmd.ready drops until res drains.
module region_time_profiler_core #(
	parameter int unsigned REGION_COUNT = rtp_pkg::REGION_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	rtp_in_if.sink           cmd,
	rtp_out_if.source        res
);

	localparam int unsigned IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

	// input stage
	logic                             valid_s1;
	rtp_pkg::op_t                     op_s1;
	logic [rtp_pkg::REGION_W-1:0]     region_s1;
	logic [rtp_pkg::TIME_W-1:0]       now_s1;

	// record table
	rtp_pkg::rec_t                    tab_q [REGION_COUNT];
	logic [REGION_COUNT-1:0]          vld_q;

	// result register
	logic                             res_valid_q;
	logic [rtp_pkg::STATUS_W-1:0]     status_q;
	logic [rtp_pkg::MARK_W-1:0]       mark_q;
	rtp_pkg::rec_t                    rec_q;

	logic                             advance;
	logic                             fire;
	logic [IDX_W-1:0]                 idx;
	logic                             in_range;
	rtp_pkg::rec_t                    rd_rec;
	rtp_pkg::rec_t                    new_rec;
	rtp_pkg::rec_t                    out_rec;
	logic [rtp_pkg::STATUS_W-1:0]     status_d;
	logic [rtp_pkg::MARK_W-1:0]       mark_d;
	logic                             wr_en;
	logic [rtp_pkg::TIME_W:0]         elapsed;

	// result register frees when empty or being taken
	assign advance   = !res_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign fire      = valid_s1 && advance;

	assign idx      = region_s1[IDX_W-1:0];
	assign in_range = (9'(region_s1) < 9'(REGION_COUNT));
	assign rd_rec   = vld_q[idx] ? tab_q[idx] : '0;

	// now - stamp with borrow: top bit set means time went backwards
	assign elapsed  = {1'b0, now_s1} - {1'b0, rd_rec.start_stamp};

	always_comb begin
		new_rec  = rd_rec;
		status_d = rtp_pkg::ST_OK;
		mark_d   = rtp_pkg::MARK_NONE;
		wr_en    = 1'b0;
		out_rec  = '0;
		case (op_s1)
			rtp_pkg::OP_ENTER: begin
				new_rec.entry_total = rd_rec.entry_total + 32'd1;
				new_rec.start_stamp = now_s1;
				new_rec.region_open = 1'b1;
				mark_d              = rtp_pkg::MARK_ENTER;
				wr_en               = in_range;
			end
			rtp_pkg::OP_EXIT: begin
				new_rec.exit_total = rd_rec.exit_total + 32'd1;
				if (rd_rec.region_open) begin
					if (!elapsed[rtp_pkg::TIME_W])
						new_rec.busy_time = rd_rec.busy_time + elapsed[rtp_pkg::TIME_W-1:0];
					new_rec.region_open = 1'b0;
				end else begin
					status_d = rtp_pkg::ST_NO_ENTER;
				end
				mark_d = rtp_pkg::MARK_EXIT;
				wr_en  = in_range;
			end
			rtp_pkg::OP_READ: begin
			end
			rtp_pkg::OP_CLEAR: begin
			end
			default: begin
			end
		endcase
		if (op_s1 == rtp_pkg::OP_CLEAR) begin
			status_d = rtp_pkg::ST_OK;
			mark_d   = rtp_pkg::MARK_NONE;
		end else if (!in_range) begin
			status_d = rtp_pkg::ST_RANGE;
			mark_d   = rtp_pkg::MARK_NONE;
		end else begin
			out_rec = new_rec;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			if (cmd.ready)
				valid_s1 <= cmd.valid;
			if (advance)
				res_valid_q <= valid_s1;
			if (fire) begin
				if (op_s1 == rtp_pkg::OP_CLEAR)
					vld_q <= '0;
				else if (wr_en)
					vld_q[idx] <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1     <= rtp_pkg::op_t'(cmd.opcode);
			region_s1 <= cmd.region;
			now_s1    <= cmd.now_time;
		end
		if (fire) begin
			status_q <= status_d;
			mark_q   <= mark_d;
			rec_q    <= out_rec;
			if (wr_en)
				tab_q[idx] <= new_rec;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = status_q;
	assign res.edge_mark   = mark_q;
	assign res.entry_total = rec_q.entry_total;
	assign res.exit_total  = rec_q.exit_total;
	assign res.busy_time   = rec_q.busy_time;
	assign res.start_stamp = rec_q.start_stamp;
	assign res.region_open = rec_q.region_open;

endmodule

// ===== rtl/rtp_checker.sv =====
module rtp_sva (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [rtp_pkg::STATUS_W-1:0]  status,
	input logic [rtp_pkg::MARK_W-1:0]    edge_mark,
	input logic [rtp_pkg::COUNT_W-1:0]   entry_total,
	input logic [rtp_pkg::COUNT_W-1:0]   exit_total,
	input logic [rtp_pkg::TIME_W-1:0]    busy_time,
	input logic [rtp_pkg::TIME_W-1:0]    start_stamp,
	input logic                          region_open
);

	// stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// range error carries an empty record and no mark
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == rtp_pkg::ST_RANGE |->
		edge_mark == rtp_pkg::MARK_NONE && entry_total == '0 && exit_total == '0 &&
		busy_time == '0 && start_stamp == '0 && !region_open)
		else $error("range error with nonzero record");

	// enter leaves the region open with a clean status
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && edge_mark == rtp_pkg::MARK_ENTER |->
		region_open && status == rtp_pkg::ST_OK)
		else $error("enter did not open region");

	// exit always leaves the region closed
	a_exit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && edge_mark == rtp_pkg::MARK_EXIT |->
		!region_open && (status == rtp_pkg::ST_OK || status == rtp_pkg::ST_NO_ENTER))
		else $error("exit left region open");

endmodule

bind region_time_profiler_core rtp_sva u_rtp_sva (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.status      (res.status),
	.edge_mark   (res.edge_mark),
	.entry_total (res.entry_total),
	.exit_total  (res.exit_total),
	.busy_time   (res.busy_time),
	.start_stamp (res.start_stamp),
	.region_open (res.region_open)
);
